// ===== rtl/tmm_pkg.sv =====
// Shared widths, constants, state codes and control structs for threshold_masked_mean.
`default_nettype none

package tmm_pkg;

    localparam int PIX_W  = 8;
    localparam int CNT_W  = 25;
    localparam int SUM_W  = 32;
    localparam int FRAC_W = 8;
    localparam int MEAN_W = 2 * FRAC_W;
    localparam int STEP_W = $clog2(MEAN_W + 1);

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(128);
    localparam logic [PIX_W-1:0] MASK_ON         = {PIX_W{1'b1}};
    localparam logic [PIX_W-1:0] MASK_OFF        = {PIX_W{1'b0}};
    localparam logic [CNT_W-1:0] COUNT_MAX       = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic pix_accept;
        logic load_pix;
        logic div_start;
        logic load_stat;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/tmm_if.sv =====
// Channel interfaces: pixel input, result output and threshold write.
`default_nettype none

interface tmm_pix_if;
    logic                      valid;
    logic                      ready;
    logic [tmm_pkg::PIX_W-1:0] pixel;
    logic                      last_pixel;

    modport source (output valid, pixel, last_pixel, input ready);
    modport sink   (input valid, pixel, last_pixel, output ready);
endinterface

interface tmm_res_if;
    logic                       valid;
    logic                       ready;
    logic [tmm_pkg::PIX_W-1:0]  mask;
    logic                       image_done;
    logic [tmm_pkg::CNT_W-1:0]  masked_count;
    logic [tmm_pkg::SUM_W-1:0]  masked_sum;
    logic [tmm_pkg::MEAN_W-1:0] mean_q8;
    logic                       none_masked;

    modport source (output valid, mask, image_done, masked_count, masked_sum, mean_q8,
                    none_masked, input ready);
    modport sink   (input valid, mask, image_done, masked_count, masked_sum, mean_q8,
                    none_masked, output ready);
endinterface

interface tmm_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tmm_pkg::PIX_W-1:0] threshold;

    modport source (output valid, threshold, input ready);
    modport sink   (input valid, threshold, output ready);
endinterface

`default_nettype wire

// ===== rtl/threshold_masked_mean.sv =====
// Top level of threshold_masked_mean: binary threshold mask with per-image masked mean.
//
//  channel  | modport | beat carries
//  ---------+---------+--------------------------------------------------------------
//  pixels   | sink    | pixel[7:0], last_pixel
//  results  | source  | mask, image_done, masked_count, masked_sum, mean_q8, none_masked
//  cfg      | sink    | threshold[7:0], always ready
//
//  An ordinary pixel's result beat is registered on the edge that accepts
//  it, so pixels stream at one per cycle while no image end is in progress.
//  The last pixel of an image is accepted, then goes through 16 steps of the
//  bit-serial divider (one quotient bit each), then the result load.
//  Reset clears the accumulators and sets the threshold to 128.
//  A stalled result holds its register; pixels keep flowing as long as the
//  result register empties in the same cycle.
`default_nettype none

module threshold_masked_mean (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tmm_pix_if.sink    pixels,
    tmm_res_if.source  results,
    tmm_cfg_if.sink    cfg
);

    tmm_pkg::cmd_t    cmd;
    tmm_pkg::status_t status;

    // Threshold writes are taken at any time; the user only writes while idle.
    assign cfg.ready = 1'b1;

    // Sequence the image end and own the result-valid flag.
    tmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixels.valid),
        .in_last   (pixels.last_pixel),
        .in_ready  (pixels.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Compare, accumulate, divide and hold the result beat.
    tmm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg.valid),
        .cfg_threshold (cfg.threshold),
        .pixel         (pixels.pixel),
        .mask          (results.mask),
        .image_done    (results.image_done),
        .masked_count  (results.masked_count),
        .masked_sum    (results.masked_sum),
        .mean_q8       (results.mean_q8),
        .none_masked   (results.none_masked)
    );

endmodule

`default_nettype wire

// ===== rtl/tmm_div.sv =====
// Bit-serial restoring divider giving the Q8.8 mean, one quotient bit a cycle.
`default_nettype none

module tmm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tmm_pkg::SUM_W-1:0]  dividend,
    input  wire logic [tmm_pkg::CNT_W-1:0]  divisor,
    output logic                            done,
    output logic [tmm_pkg::MEAN_W-1:0]      quotient
);

    logic                        busy_reg;
    logic [tmm_pkg::STEP_W-1:0]  step_reg;
    logic [tmm_pkg::CNT_W-1:0]   rem_reg;
    logic [tmm_pkg::MEAN_W-1:0]  low_reg;
    logic [tmm_pkg::MEAN_W-1:0]  quo_reg;

    logic [tmm_pkg::CNT_W:0]     shifted;
    logic [tmm_pkg::CNT_W:0]     diff;
    logic                        ge;

    // Sum never exceeds 255 * count, so the quotient fits MEAN_W bits and
    // the top part of the dividend is already below the divisor.
    assign shifted = {rem_reg, low_reg[tmm_pkg::MEAN_W-1]};
    assign diff    = shifted - {1'b0, divisor};
    assign ge      = (shifted >= {1'b0, divisor});

    assign done     = busy_reg && (step_reg == tmm_pkg::STEP_W'(1));
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= tmm_pkg::STEP_W'(tmm_pkg::MEAN_W);
        end
        else if (busy_reg) begin
            step_reg <= step_reg - tmm_pkg::STEP_W'(1);
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= tmm_pkg::CNT_W'(dividend[tmm_pkg::SUM_W-1:tmm_pkg::FRAC_W]);
            low_reg <= {dividend[tmm_pkg::FRAC_W-1:0], {tmm_pkg::FRAC_W{1'b0}}};
            quo_reg <= '0;
        end
        else if (busy_reg) begin
            rem_reg <= ge ? diff[tmm_pkg::CNT_W-1:0] : shifted[tmm_pkg::CNT_W-1:0];
            low_reg <= {low_reg[tmm_pkg::MEAN_W-2:0], 1'b0};
            quo_reg <= {quo_reg[tmm_pkg::MEAN_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tmm_dpath.sv =====
// Datapath: threshold register, mask compare, saturating accumulators, result register.
`default_nettype none

module tmm_dpath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire tmm_pkg::cmd_t              cmd,
    output tmm_pkg::status_t                status,
    input  wire logic                       cfg_we,
    input  wire logic [tmm_pkg::PIX_W-1:0]  cfg_threshold,
    input  wire logic [tmm_pkg::PIX_W-1:0]  pixel,
    output logic [tmm_pkg::PIX_W-1:0]       mask,
    output logic                            image_done,
    output logic [tmm_pkg::CNT_W-1:0]       masked_count,
    output logic [tmm_pkg::SUM_W-1:0]       masked_sum,
    output logic [tmm_pkg::MEAN_W-1:0]      mean_q8,
    output logic                            none_masked
);

    logic [tmm_pkg::PIX_W-1:0]  threshold_reg;
    logic [tmm_pkg::CNT_W-1:0]  acc_cnt_reg;
    logic [tmm_pkg::SUM_W-1:0]  acc_sum_reg;
    logic [tmm_pkg::CNT_W-1:0]  stat_cnt_reg;
    logic [tmm_pkg::SUM_W-1:0]  stat_sum_reg;
    logic                       mask_hold_reg;

    logic [tmm_pkg::PIX_W-1:0]  mask_reg;
    logic                       done_reg;
    logic [tmm_pkg::CNT_W-1:0]  count_reg;
    logic [tmm_pkg::SUM_W-1:0]  sum_reg;
    logic [tmm_pkg::MEAN_W-1:0] mean_reg;
    logic                       none_reg;

    logic                       hit;
    logic [tmm_pkg::CNT_W-1:0]  cnt_upd;
    logic [tmm_pkg::SUM_W:0]    sum_wide;
    logic [tmm_pkg::SUM_W-1:0]  sum_upd;
    logic                       div_done;
    logic [tmm_pkg::MEAN_W-1:0] quo;

    assign hit      = (pixel > threshold_reg);
    assign sum_wide = {1'b0, acc_sum_reg} + (tmm_pkg::SUM_W + 1)'(pixel);

    always_comb begin
        cnt_upd = acc_cnt_reg;
        sum_upd = acc_sum_reg;
        if (hit) begin
            if (acc_cnt_reg != tmm_pkg::COUNT_MAX) begin
                cnt_upd = acc_cnt_reg + tmm_pkg::CNT_W'(1);
            end
            sum_upd = sum_wide[tmm_pkg::SUM_W] ? tmm_pkg::SUM_MAX
                                               : sum_wide[tmm_pkg::SUM_W-1:0];
        end
    end

    tmm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (sum_upd),
        .divisor  (stat_cnt_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign status.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            threshold_reg <= tmm_pkg::THRESHOLD_RESET;
            acc_cnt_reg   <= '0;
            acc_sum_reg   <= '0;
        end
        else begin
            if (cfg_we) begin
                threshold_reg <= cfg_threshold;
            end
            if (cmd.div_start) begin
                acc_cnt_reg <= '0;
                acc_sum_reg <= '0;
            end
            else if (cmd.pix_accept) begin
                acc_cnt_reg <= cnt_upd;
                acc_sum_reg <= sum_upd;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.div_start) begin
            stat_cnt_reg  <= cnt_upd;
            stat_sum_reg  <= sum_upd;
            mask_hold_reg <= hit;
        end
        if (cmd.load_pix) begin
            mask_reg  <= hit ? tmm_pkg::MASK_ON : tmm_pkg::MASK_OFF;
            done_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            mean_reg  <= '0;
            none_reg  <= 1'b0;
        end
        else if (cmd.load_stat) begin
            mask_reg  <= mask_hold_reg ? tmm_pkg::MASK_ON : tmm_pkg::MASK_OFF;
            done_reg  <= 1'b1;
            count_reg <= stat_cnt_reg;
            sum_reg   <= stat_sum_reg;
            mean_reg  <= (stat_cnt_reg == '0) ? '0 : quo;
            none_reg  <= (stat_cnt_reg == '0);
        end
    end

    assign mask         = mask_reg;
    assign image_done   = done_reg;
    assign masked_count = count_reg;
    assign masked_sum   = sum_reg;
    assign mean_q8      = mean_reg;
    assign none_masked  = none_reg;

endmodule

`default_nettype wire

// ===== rtl/tmm_ctrl.sv =====
// Controller: handshakes, image-end sequencing and result-valid register.
`default_nettype none

module tmm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tmm_pkg::cmd_t          cmd,
    input  wire tmm_pkg::status_t  status
);

    tmm_pkg::state_t state_reg;
    tmm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;
    logic            fire;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == tmm_pkg::ST_RUN) && slot_free;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cmd.pix_accept = fire;
        cmd.load_pix   = fire && !in_last;
        cmd.div_start  = fire && in_last;
        cmd.load_stat  = 1'b0;
        unique case (state_reg)
            tmm_pkg::ST_RUN: begin
                if (fire && in_last) begin
                    state_next = tmm_pkg::ST_DIV;
                end
            end
            tmm_pkg::ST_DIV: begin
                if (status.div_done) begin
                    state_next = tmm_pkg::ST_DONE;
                end
            end
            tmm_pkg::ST_DONE: begin
                if (slot_free) begin
                    cmd.load_stat = 1'b1;
                    state_next    = tmm_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = tmm_pkg::ST_RUN;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_pix || cmd.load_stat) begin
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
        else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= tmm_pkg::ST_RUN;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tmm_checker.sv =====
// Port-level checker for threshold_masked_mean and its bind.
`default_nettype none

module tmm_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic [tmm_pkg::PIX_W-1:0]  mask,
    input  wire logic                       image_done,
    input  wire logic [tmm_pkg::CNT_W-1:0]  masked_count,
    input  wire logic [tmm_pkg::SUM_W-1:0]  masked_sum,
    input  wire logic [tmm_pkg::MEAN_W-1:0] mean_q8,
    input  wire logic                       none_masked
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mask) && $stable(image_done)
            && $stable(masked_count) && $stable(mean_q8))
        else $error("stalled result beat changed");

    a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mask == tmm_pkg::MASK_ON) || (mask == tmm_pkg::MASK_OFF))
        else $error("mask byte neither on nor off");

    a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !image_done |-> (masked_count == '0) && (masked_sum == '0)
            && (mean_q8 == '0) && !none_masked)
        else $error("statistics present on a non-final beat");

    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> (none_masked == (masked_count == '0))
            && (!none_masked || ((mean_q8 == '0) && (masked_sum == '0))))
        else $error("none_masked inconsistent with count, sum or mean");

endmodule

bind threshold_masked_mean tmm_checker u_tmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .mask         (results.mask),
    .image_done   (results.image_done),
    .masked_count (results.masked_count),
    .masked_sum   (results.masked_sum),
    .mean_q8      (results.mean_q8),
    .none_masked  (results.none_masked)
);

`default_nettype wire
